[hdl/heading_from_vector_assert.svh]
// Assertion macros for the heading_from_vector block.
// Used by the port-level checker; no other dependencies.
`ifndef HEADING_FROM_VECTOR_ASSERT_SVH
`define HEADING_FROM_VECTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define HFV_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heading_from_vector: assertion failed");

// next-cycle implication, disabled while reset is low
`define HFV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heading_from_vector: assertion failed");

`endif

[hdl/hfv_pkg.sv]
// Shared constants, angle table and stage type for heading_from_vector.
// No dependencies; imported by every module of the block.
package hfv_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 6;

    // angle accumulator counts 2^-24 degree
    localparam int ANG_FRAC  = 24;
    localparam int ATAN_LEN  = 24;
    localparam int NUM_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int SHIFT_W   = $clog2(ATAN_LEN);

    // sqrt(2) * gain 1.647 stays below 4x the input range
    localparam int XY_W      = COORD_WIDTH + 3;
    localparam int Z_W       = 34;
    localparam int RND_SHIFT = ANG_FRAC - FRAC_BITS;
    localparam int HEADING_W = 15;

    localparam int S_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((HEADING_W + 7) / 8) * 8;

    localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(64'sd90 <<< ANG_FRAC);
    localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(64'sd1 <<< (RND_SHIFT - 1));
    localparam logic signed [Z_W-1:0] FULL_TURN = Z_W'(64'sd360 <<< FRAC_BITS);
    localparam logic [M_DATA_W-1:0]   HEADING_LIMIT = M_DATA_W'(64'd360 << FRAC_BITS);

    // atan(2^-i) in 2^-24 degree
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        Z_W'(754974720), Z_W'(445687602), Z_W'(235489088), Z_W'(119537938),
        Z_W'(60000934),  Z_W'(30029717),  Z_W'(15018523),  Z_W'(7509720),
        Z_W'(3754917),   Z_W'(1877466),   Z_W'(938734),    Z_W'(469367),
        Z_W'(234684),    Z_W'(117342),    Z_W'(58671),     Z_W'(29335),
        Z_W'(14668),     Z_W'(7334),      Z_W'(3667),      Z_W'(1833),
        Z_W'(917),       Z_W'(458),       Z_W'(229),       Z_W'(115)
    };

    typedef struct packed {
        logic                  zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } hfv_stage_t;

endpackage

[hdl/hfv_prerot.sv]
// Input stage: unpacks the word, applies y flip, zero detect and the
// half-plane pre-rotation. Depends on hfv_pkg.
module hfv_prerot (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          y_axis_down,
    input  logic                          in_valid,
    input  logic [hfv_pkg::S_DATA_W-1:0]  in_data,
    output logic                          out_valid,
    output hfv_pkg::hfv_stage_t           out_stage
);
    import hfv_pkg::*;

    logic                   valid_reg;
    hfv_stage_t             stage_reg;
    hfv_stage_t             stage_next;
    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;

    always_comb begin
        x_in = XY_W'($signed(in_data[COORD_WIDTH-1:0]));
        y_in = XY_W'($signed(in_data[2*COORD_WIDTH-1:COORD_WIDTH]));
        stage_next.zero = (x_in == '0) && (y_in == '0);
        if (y_axis_down) begin
            y_in = -y_in;
        end
        stage_next.x = x_in;
        stage_next.y = y_in;
        stage_next.z = '0;
        // left half plane: turn by 90 degrees toward the right half
        if (x_in[XY_W-1]) begin
            if (!y_in[XY_W-1]) begin
                stage_next.x = y_in;
                stage_next.y = -x_in;
                stage_next.z = Z_QUARTER;
            end else begin
                stage_next.x = -y_in;
                stage_next.y = x_in;
                stage_next.z = -Z_QUARTER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[hdl/hfv_cell.sv]
// One CORDIC vectoring iteration with its pipeline register.
// Depends on hfv_pkg.
module hfv_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [hfv_pkg::SHIFT_W-1:0]   shift,
    input  logic signed [hfv_pkg::Z_W-1:0] atan_step,
    input  logic                          in_valid,
    input  hfv_pkg::hfv_stage_t           in_stage,
    output logic                          out_valid,
    output hfv_pkg::hfv_stage_t           out_stage
);
    import hfv_pkg::*;

    logic                   valid_reg;
    hfv_stage_t             stage_reg;
    hfv_stage_t             stage_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    always_comb begin
        xs = in_stage.x >>> shift;
        ys = in_stage.y >>> shift;
        stage_next.zero = in_stage.zero;
        if (!in_stage.y[XY_W-1]) begin
            stage_next.x = in_stage.x + ys;
            stage_next.y = in_stage.y - xs;
            stage_next.z = in_stage.z + atan_step;
        end else begin
            stage_next.x = in_stage.x - ys;
            stage_next.y = in_stage.y + xs;
            stage_next.z = in_stage.z - atan_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

[hdl/hfv_post.sv]
// Output stage: adds 90 degrees, rounds to the output grid, wraps into
// [0, 360) and holds the result word. Depends on hfv_pkg.
module hfv_post (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  hfv_pkg::hfv_stage_t           in_stage,
    output logic                          m_axis_tvalid,
    output logic [hfv_pkg::M_DATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser
);
    import hfv_pkg::*;

    logic                   valid_reg;
    logic [HEADING_W-1:0]   heading_reg;
    logic [HEADING_W-1:0]   heading_next;
    logic                   zero_reg;
    logic signed [Z_W-1:0]  sum;
    logic signed [Z_W-1:0]  r;
    logic signed [Z_W-1:0]  r_wrap;

    always_comb begin
        sum = in_stage.z + Z_QUARTER + Z_HALF;
        r   = sum >>> RND_SHIFT;
        if (r[Z_W-1]) begin
            r_wrap = r + FULL_TURN;
        end else if (r >= FULL_TURN) begin
            r_wrap = r - FULL_TURN;
        end else begin
            r_wrap = r;
        end
        heading_next = in_stage.zero ? '0 : r_wrap[HEADING_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            heading_reg <= heading_next;
            zero_reg    <= in_stage.zero;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - HEADING_W){1'b0}}, heading_reg};
    assign m_axis_tuser  = zero_reg;

endmodule

[hdl/heading_from_vector.sv]
// heading_from_vector: compass heading of a signed 2-D vector.
// Input word on s_axis: vec_x in the low COORD_WIDTH bits, vec_y above it.
// Result word on m_axis: heading in 1/64 degree (0 .. 359.984 deg) in
// tdata, tuser = 1 when the vector was zero (heading then reads 0).
// cfg_wr_en/cfg_wr_data write y_axis_down (1 = flip y before the angle);
// write only while no word is in flight.
// Pipeline: input stage, one CORDIC cell per iteration, output register.
// Throughput: one word per cycle unless m_axis stalls, set by the row of
// pipelined iteration cells; each cell register loads on every advance.
// The whole pipe advances when the output register is empty or taken, so
// s_axis_tready follows that condition; a stalled receiver freezes the
// pipe and the pending word holds on m_axis.
// Reset (aresetn low, synchronous) clears all valid flags and sets
// y_axis_down to 0; no clearing pass is needed.
// Depends on hfv_pkg, hfv_prerot, hfv_cell, hfv_post.
module heading_from_vector (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,   // y_axis_down
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hfv_pkg::S_DATA_W-1:0]  s_axis_tdata,  // vec_x, vec_y
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hfv_pkg::M_DATA_W-1:0]  m_axis_tdata,  // heading, zero pad
    output logic                          m_axis_tuser   // zero_vector
);
    import hfv_pkg::*;

    logic       y_axis_down_reg;
    logic       adv;
    logic       valid_pipe [0:NUM_STEPS];
    hfv_stage_t stage_pipe [0:NUM_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_axis_down_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            y_axis_down_reg <= cfg_wr_data;
        end
    end

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    hfv_prerot u_prerot (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .y_axis_down (y_axis_down_reg),
        .in_valid    (s_axis_tvalid),
        .in_data     (s_axis_tdata),
        .out_valid   (valid_pipe[0]),
        .out_stage   (stage_pipe[0])
    );

    for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
        hfv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .shift     (SHIFT_W'(i)),
            .atan_step (ATAN_TAB[i]),
            .in_valid  (valid_pipe[i]),
            .in_stage  (stage_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_stage (stage_pipe[i+1])
        );
    end

    hfv_post u_post (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (valid_pipe[NUM_STEPS]),
        .in_stage      (stage_pipe[NUM_STEPS]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[hdl/hfv_checker.sv]
// Port-level checker for heading_from_vector, attached by bind.
// Depends on hfv_pkg and heading_from_vector_assert.svh.
`include "heading_from_vector_assert.svh"

module hfv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [hfv_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input logic                          m_axis_tuser
);
    import hfv_pkg::*;

    // heading always inside one turn
    `HFV_ASSERT_IMPL(a_heading_range, aclk, aresetn, m_axis_tvalid,
                     m_axis_tdata < HEADING_LIMIT)
    // zero vector reports heading 0
    `HFV_ASSERT_IMPL(a_zero_heading, aclk, aresetn, m_axis_tvalid && m_axis_tuser,
                     m_axis_tdata == '0)
    // a held result word stalls the input side
    `HFV_ASSERT_IMPL(a_stall_back, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     !s_axis_tready)
    // stalled word holds
    `HFV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind heading_from_vector hfv_checker u_hfv_checker (.*);

[dv/heading_from_vector_tb.sv]
// Self-checking testbench for heading_from_vector: stream in 2-D vectors, check heading words.
// A directed table runs first, then random phases with idle gaps and register changes.
// Depends on hfv_pkg and the heading_from_vector RTL only.
`timescale 1ns / 1ps

module heading_from_vector_tb;
    import hfv_pkg::*;

    localparam int  PIPE_LAT    = NUM_STEPS + 2;
    localparam int  HOLD_CYCLES = 200;
    localparam int  PHASES      = 7;
    localparam int  PHASE_WORDS = 200;
    localparam longint CYCLE_LIMIT = 600000;

    // atan(2^-i) in units of 2^-24 degree
    localparam longint ATAN_DEG [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [HEADING_W-1:0] heading;
        logic                 zero;
    } heading_res_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        bit                            typed;
        heading_res_t                  res;
    } vec_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic                 cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;   // vec_x, vec_y
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;   // heading, zero pad
    logic                 m_axis_tuser;   // zero_vector

    heading_res_t heading_q [$];
    heading_res_t got_res;
    bit           y_down_model;
    bit           tx_idle_en;
    bit           rx_idle_en;
    bit           hold_req;
    int           errors;
    int           words_sent;
    int           words_seen;
    int           zeros_seen;
    int           cfg_writes;
    longint       cycle_count;

    heading_from_vector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                 heading_q.size());
        $display("TEST FAILED");
        $finish;
    end

    // CORDIC vectoring in 64-bit signed arithmetic, angle in 2^-24 degree
    function automatic heading_res_t predict_heading(input logic signed [COORD_WIDTH-1:0] vx,
                                                     input logic signed [COORD_WIDTH-1:0] vy,
                                                     input bit flip_y);
        longint x, y, z, t, xs, ys, r;
        longint full;
        heading_res_t res;
        x = vx;
        y = vy;
        z = 0;
        full = longint'(360) <<< FRAC_BITS;
        if (x == 0 && y == 0) begin
            res.heading = '0;
            res.zero    = 1'b1;
            return res;
        end
        if (flip_y) y = -y;
        // left half plane: turn by 90 degrees first
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = longint'(90) <<< ANG_FRAC;
            end else begin
                x = -y;
                y = t;
                z = -(longint'(90) <<< ANG_FRAC);
            end
        end
        for (int i = 0; i < NUM_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG[i];
            end
        end
        z = z + (longint'(90) <<< ANG_FRAC);
        r = (z + (longint'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
        while (r < 0) r = r + full;
        while (r >= full) r = r - full;
        res.heading = r[HEADING_W-1:0];
        res.zero    = 1'b0;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] edge_coord();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    task automatic rand_vec(output logic signed [COORD_WIDTH-1:0] vx,
                            output logic signed [COORD_WIDTH-1:0] vy);
        int r;
        r = $urandom_range(0, 99);
        vx = COORD_WIDTH'($urandom_range(0, 65535));
        vy = COORD_WIDTH'($urandom_range(0, 65535));
        if (r < 50) begin
        end else if (r < 65) begin
            vx = edge_coord();
            vy = edge_coord();
        end else if (r < 80) begin
            vx = COORD_WIDTH'($urandom_range(0, 16) - 8);
            vy = COORD_WIDTH'($urandom_range(0, 16) - 8);
        end else if (r < 90) begin
            // on an axis
            if ($urandom_range(0, 1)) vx = '0;
            else vy = '0;
        end else begin
            vy = $urandom_range(0, 1) ? vx : -vx;
        end
    endtask

    task automatic send_vec(input logic signed [COORD_WIDTH-1:0] vx,
                            input logic signed [COORD_WIDTH-1:0] vy,
                            input bit typed, input heading_res_t typed_res);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vy, vx};
        do @(posedge aclk); while (!s_axis_tready);
        heading_q.push_back(typed ? typed_res : predict_heading(vx, vy, y_down_model));
        words_sent++;
    endtask

    // stop offering, wait for every result, then let the pipe empty out
    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (heading_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
    endtask

    task automatic set_y_axis_down(input bit v);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        y_down_model = v;
        cfg_writes++;
    endtask

    // receiver: random stalls, plus one long hold on request
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = HOLD_CYCLES;
            end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
                stall = pick_gap();
            end else begin
                stall = 0;
            end
            if (stall == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            words_seen++;
            if (m_axis_tuser) zeros_seen++;
            if (heading_q.size() == 0) begin
                $error("unexpected result word: heading %0d zero_vector %0b",
                       m_axis_tdata[HEADING_W-1:0], m_axis_tuser);
                errors++;
            end else begin
                got_res = heading_q.pop_front();
                if (m_axis_tdata[HEADING_W-1:0] !== got_res.heading) begin
                    $error("heading: expected %0d, got %0d", got_res.heading,
                           m_axis_tdata[HEADING_W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[M_DATA_W-1:HEADING_W] !== '0) begin
                    $error("tdata pad: expected 0, got %0h", m_axis_tdata[M_DATA_W-1:HEADING_W]);
                    errors++;
                end
                if (m_axis_tuser !== got_res.zero) begin
                    $error("zero_vector: expected %0b, got %0b", got_res.zero, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        vec_row_t rows [12];
        logic signed [COORD_WIDTH-1:0] vx, vy;
        heading_res_t none;

        none = '0;
        rows[0]  = '{16'sd0,      16'sd0,      1'b1, '{15'd0, 1'b1}};
        rows[1]  = '{16'sd1,      16'sd0,      1'b0, '0};
        rows[2]  = '{-16'sd1,     16'sd0,      1'b0, '0};
        rows[3]  = '{16'sd0,      16'sd1,      1'b0, '0};
        // pointing straight down, where the wrap into [0, 360) happens
        rows[4]  = '{16'sd0,      -16'sd32768, 1'b0, '0};
        rows[5]  = '{-16'sd1,     -16'sd32768, 1'b0, '0};
        rows[6]  = '{16'sd1,      -16'sd32768, 1'b0, '0};
        rows[7]  = '{16'sd32767,  16'sd32767,  1'b0, '0};
        rows[8]  = '{-16'sd32768, -16'sd32768, 1'b0, '0};
        rows[9]  = '{-16'sd32768, 16'sd32767,  1'b0, '0};
        rows[10] = '{16'sd32767,  -16'sd32768, 1'b0, '0};
        rows[11] = '{-16'sd32768, 16'sd0,      1'b0, '0};

        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        y_down_model  = 1'b0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        errors        = 0;
        words_sent    = 0;
        words_seen    = 0;
        zeros_seen    = 0;
        cfg_writes    = 0;
        cycle_count   = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table: once with the reset setting, once with y flipped
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) set_y_axis_down(1'b1);
            foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            set_y_axis_down(p == 0 ? 1'b0 : (p == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
            tx_idle_en = (p != 2 && p != 3);
            rx_idle_en = (p != 3);
            // sender keeps offering while the receiver holds off
            if (p == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                rand_vec(vx, vy);
                send_vec(vx, vy, 1'b0, none);
            end
        end

        drain_results();
        repeat (2 * PIPE_LAT) @(posedge aclk);
        if (heading_q.size() != 0) begin
            $error("%0d expected result words never arrived", heading_q.size());
            errors++;
        end

        $display("Sent %0d vectors (24 from the table), checked %0d heading words, %0d zero",
                 words_sent, words_seen, zeros_seen);
        $display("%0d y_axis_down writes, one %0d-cycle receiver hold, full drains between phases",
                 cfg_writes, HOLD_CYCLES);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
